// ===== src/mt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt_pkg: shared types and constants for the MT19937 generator
// Word type, state geometry, seeding and tempering constants, request codes.
// ----------------------------------------------------------------------------
package mt_pkg;

    typedef logic [31:0] t_word;

    localparam int unsigned STATE_LEN  = 624;
    localparam int unsigned MID_OFFSET = 397;
    localparam int unsigned IDX_W      = 10;

    localparam t_word INIT_MULT   = 32'd1812433253;
    localparam t_word MIX1_MULT   = 32'd1664525;
    localparam t_word MIX2_MULT   = 32'd1566083941;
    localparam t_word ARRAY_SEED  = 32'd19650218;
    localparam t_word TOP_BIT     = 32'h8000_0000;
    localparam t_word TWIST_XOR   = 32'h9908_b0df;
    localparam t_word TEMPER_B    = 32'h9d2c_5680;
    localparam t_word TEMPER_C    = 32'hefc6_0000;

    typedef enum logic [1:0] {
        REQ_SEED = 2'd0,
        REQ_KEY  = 2'd1,
        REQ_DRAW = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    // power-on key {0x123, 0x234, 0x345, 0x456}
    function automatic t_word default_key(input logic [1:0] idx);
        t_word v;
        case (idx)
            2'd0:    v = 32'h0000_0123;
            2'd1:    v = 32'h0000_0234;
            2'd2:    v = 32'h0000_0345;
            default: v = 32'h0000_0456;
        endcase
        return v;
    endfunction

endpackage

// ===== src/mt19937_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt19937_generator_top: MT19937 32-bit random number generator
// Sequenced generator around one shared multiplier and a 624-word state RAM.
// ----------------------------------------------------------------------------
// A transaction is taken when i_start is high and o_busy is low; the block then
// stays busy until the request is done. A draw (req 2) returns one tempered
// word on o_rand_value with o_valid high for exactly one cycle; the receiver
// cannot stall, so capture it then. The state is regenerated lazily, one word
// per draw (three state RAM reads, one write), so every draw runs the same
// read, read, read, write sequence. A scalar seed (req 0) fills the state with
// one multiply per word after the first. A key word (req 1) is stored in the
// key buffer; the one flagged i_key_last starts array seeding: a scalar pass
// plus 624 + 623 mixing steps. After reset the block runs the same array
// seeding with the default key and is busy until it is done. Key words past
// KEY_DEPTH are dropped; request code 3 is accepted and ignored.
// ----------------------------------------------------------------------------
module mt19937_generator_top #(
    parameter int KEY_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_seed_value,
    input  logic [31:0] i_key_word,
    input  logic        i_key_last,
    output logic        o_valid,
    output logic [31:0] o_rand_value
);

    localparam int IW  = mt_pkg::IDX_W;
    localparam int KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    // count must also hold the default key length of four
    localparam int CW  = ($clog2(KEY_DEPTH + 1) > 3) ? $clog2(KEY_DEPTH + 1) : 3;
    localparam logic [IW-1:0] LAST_IDX = IW'(mt_pkg::STATE_LEN - 1);

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_SS_START = 11'b000_0000_0010,
        ST_SS_MUL   = 11'b000_0000_0100,
        ST_SS_WR    = 11'b000_0000_1000,
        ST_AS_RD    = 11'b000_0001_0000,
        ST_AS_WR    = 11'b000_0010_0000,
        ST_AS_WRAP  = 11'b000_0100_0000,
        ST_AS_NEXT  = 11'b000_1000_0000,
        ST_AS_FIN   = 11'b001_0000_0000,
        ST_DR_RD0   = 11'b010_0000_0000,
        ST_DR_RD1   = 11'b100_0000_0000
    } t_state_a;

    // draw tail states kept in a second small enum-free flag pair
    t_state_a r_state;
    logic     r_dr_rd2;   // third read of a draw
    logic     r_dr_wr;    // result/write cycle of a draw

    // sequencer registers
    logic [IW-1:0]  r_idx;     // next word to regenerate and read
    logic [IW-1:0]  r_i;       // seeding word index
    logic [IW-1:0]  r_k;       // remaining mixing steps
    logic [CW-1:0]  r_j;       // key index
    logic [CW-1:0]  r_len;     // key length
    logic [CW-1:0]  r_kcnt;    // stored key words
    logic           r_arr;     // scalar pass belongs to array seeding
    logic           r_loop2;   // second mixing loop
    logic           r_dflt;    // use the power-on key
    mt_pkg::t_word  r_prev, r_a, r_b, r_out;
    logic           r_valid;

    // RAM / multiplier hookup
    logic           s_we;
    logic [IW-1:0]  s_waddr, s_raddr;
    mt_pkg::t_word  s_wdata, s_rdata;
    logic           k_we;
    mt_pkg::t_word  k_rdata;
    mt_pkg::t_word  w_prod, w_x, w_mulb, w_key, w_mix, w_word, w_y, w_gen;
    logic [IW-1:0]  w_idx1, w_idxm;
    logic [IW:0]    w_sum_m;
    logic           w_acc, w_kfull;
    logic [CW-1:0]  w_kcnt_nx, w_j_nx;
    logic           w_draw;

    function automatic mt_pkg::t_word temper(input mt_pkg::t_word v);
        mt_pkg::t_word t;
        t = v ^ (v >> 11);
        t = t ^ ((t << 7) & mt_pkg::TEMPER_B);
        t = t ^ ((t << 15) & mt_pkg::TEMPER_C);
        t = t ^ (t >> 18);
        return t;
    endfunction

    assign w_draw = r_dr_rd2 | r_dr_wr;
    assign o_busy = (r_state != ST_IDLE) | w_draw;
    assign w_acc  = i_start & ~o_busy;

    assign w_kfull   = (r_kcnt >= CW'(KEY_DEPTH));
    assign w_kcnt_nx = w_kfull ? r_kcnt : CW'(r_kcnt + 1'b1);
    assign w_j_nx    = (CW'(r_j + 1'b1) >= r_len) ? '0 : CW'(r_j + 1'b1);

    // neighbor indices for the twist, mod STATE_LEN
    assign w_idx1  = (r_idx == LAST_IDX) ? '0 : IW'(r_idx + 1'b1);
    assign w_sum_m = (IW+1)'(r_idx) + (IW+1)'(mt_pkg::MID_OFFSET);
    assign w_idxm  = (w_sum_m >= (IW+1)'(mt_pkg::STATE_LEN))
                     ? IW'(w_sum_m - (IW+1)'(mt_pkg::STATE_LEN)) : IW'(w_sum_m);

    // shared multiplier operands
    assign w_x    = r_prev ^ (r_prev >> 30);
    assign w_mulb = (r_state == ST_SS_MUL) ? mt_pkg::INIT_MULT
                  : (r_loop2 ? mt_pkg::MIX2_MULT : mt_pkg::MIX1_MULT);

    mt_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_x),
        .i_b   (w_mulb),
        .o_p   (w_prod)
    );

    assign w_key  = r_dflt ? mt_pkg::default_key(r_j[1:0]) : k_rdata;
    assign w_mix  = s_rdata ^ w_prod;
    assign w_word = r_loop2 ? (w_mix - 32'(r_i)) : (w_mix + w_key + 32'(r_j));

    assign w_y   = {r_a[31], r_b[30:0]};
    assign w_gen = s_rdata ^ (w_y >> 1) ^ (w_y[0] ? mt_pkg::TWIST_XOR : '0);

    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_i;
        s_wdata = w_word;
        s_raddr = r_i;
        if (r_dr_rd2) begin
            s_raddr = w_idxm;
        end else if (r_dr_wr) begin
            s_we    = 1'b1;
            s_waddr = r_idx;
            s_wdata = w_gen;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_acc && i_req_type == mt_pkg::REQ_SEED) begin
                        s_we    = 1'b1;
                        s_waddr = '0;
                        s_wdata = i_seed_value;
                    end
                end
                ST_SS_START: begin
                    s_we    = 1'b1;
                    s_waddr = '0;
                    s_wdata = mt_pkg::ARRAY_SEED;
                end
                ST_SS_WR: begin
                    s_we    = 1'b1;
                    s_wdata = w_prod + 32'(r_i);
                end
                ST_AS_WR: begin
                    s_we = 1'b1;
                end
                ST_AS_WRAP: begin
                    s_we    = 1'b1;
                    s_waddr = '0;
                    s_wdata = r_prev;
                end
                ST_AS_FIN: begin
                    s_we    = 1'b1;
                    s_waddr = '0;
                    s_wdata = mt_pkg::TOP_BIT;
                end
                ST_DR_RD0: s_raddr = r_idx;
                ST_DR_RD1: s_raddr = w_idx1;
                default: ;
            endcase
        end
    end

    assign k_we = w_acc && (i_req_type == mt_pkg::REQ_KEY) && !w_kfull;

    mt_ram #(.WIDTH(32), .DEPTH(mt_pkg::STATE_LEN)) u_state (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    mt_ram #(.WIDTH(32), .DEPTH(KEY_DEPTH)) u_key (
        .i_clk   (i_clk),
        .i_we    (k_we),
        .i_waddr (r_kcnt[KAW-1:0]),
        .i_wdata (i_key_word),
        .i_raddr (r_j[KAW-1:0]),
        .o_rdata (k_rdata)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_SS_START;   // power-on array seeding
            r_dr_rd2 <= 1'b0;
            r_dr_wr  <= 1'b0;
            r_dflt   <= 1'b1;
            r_len    <= CW'(4);
            r_kcnt   <= '0;
            r_valid  <= 1'b0;
            r_idx    <= '0;
            r_arr    <= 1'b0;
            r_loop2  <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
        end else begin
            r_valid  <= r_dr_wr;
            r_dr_rd2 <= (r_state == ST_DR_RD1);
            r_dr_wr  <= r_dr_rd2;
            if (r_dr_rd2) begin
                r_b <= s_rdata;
            end
            if (r_dr_wr) begin
                // word regenerated in place, then tempered out
                r_out   <= temper(w_gen);
                r_idx   <= w_idx1;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        case (i_req_type)
                            mt_pkg::REQ_SEED: begin
                                r_kcnt  <= '0;
                                r_prev  <= i_seed_value;
                                r_i     <= IW'(1);
                                r_arr   <= 1'b0;
                                r_state <= ST_SS_MUL;
                            end
                            mt_pkg::REQ_KEY: begin
                                if (i_key_last) begin
                                    r_len   <= w_kcnt_nx;
                                    r_dflt  <= 1'b0;
                                    r_kcnt  <= '0;
                                    r_state <= ST_SS_START;
                                end else begin
                                    r_kcnt <= w_kcnt_nx;
                                end
                            end
                            mt_pkg::REQ_DRAW: r_state <= ST_DR_RD0;
                            default: ;
                        endcase
                    end
                end
                ST_SS_START: begin
                    r_prev  <= mt_pkg::ARRAY_SEED;
                    r_i     <= IW'(1);
                    r_arr   <= 1'b1;
                    r_loop2 <= 1'b0;
                    r_state <= ST_SS_MUL;
                end
                ST_SS_MUL: r_state <= ST_SS_WR;
                ST_SS_WR: begin
                    if (r_i == LAST_IDX) begin
                        if (r_arr) begin
                            r_prev  <= mt_pkg::ARRAY_SEED;
                            r_i     <= IW'(1);
                            r_j     <= '0;
                            r_k     <= IW'(mt_pkg::STATE_LEN);
                            r_state <= ST_AS_RD;
                        end else begin
                            r_idx   <= '0;
                            r_state <= ST_IDLE;
                        end
                    end else begin
                        r_prev  <= w_prod + 32'(r_i);
                        r_i     <= IW'(r_i + 1'b1);
                        r_state <= ST_SS_MUL;
                    end
                end
                ST_AS_RD: r_state <= ST_AS_WR;
                ST_AS_WR: begin
                    r_prev <= w_word;
                    r_k    <= IW'(r_k - 1'b1);
                    if (!r_loop2) begin
                        r_j <= w_j_nx;
                    end
                    if (r_i == LAST_IDX) begin
                        r_i     <= IW'(1);
                        r_state <= ST_AS_WRAP;
                    end else begin
                        r_i     <= IW'(r_i + 1'b1);
                        r_state <= ST_AS_NEXT;
                    end
                end
                ST_AS_WRAP: r_state <= ST_AS_NEXT;
                ST_AS_NEXT: begin
                    if (r_k == '0) begin
                        if (!r_loop2) begin
                            r_loop2 <= 1'b1;
                            r_k     <= LAST_IDX;
                            r_state <= ST_AS_RD;
                        end else begin
                            r_state <= ST_AS_FIN;
                        end
                    end else begin
                        r_state <= ST_AS_RD;
                    end
                end
                ST_AS_FIN: begin
                    r_idx   <= '0;
                    r_state <= ST_IDLE;
                end
                ST_DR_RD0: r_state <= ST_DR_RD1;
                ST_DR_RD1: begin
                    r_a      <= s_rdata;
                    r_state  <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid      = r_valid;
    assign o_rand_value = r_out;

endmodule

// ===== src/mt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== src/mt_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt_mul: shared 32x32 multiplier
// Low 32 bits of the product, registered.
// ----------------------------------------------------------------------------
module mt_mul (
    input  logic          i_clk,
    input  mt_pkg::t_word i_a,
    input  mt_pkg::t_word i_b,
    output mt_pkg::t_word o_p
);

    // only the low word is kept, so a 32-bit product suffices
    logic [31:0] w_full;

    assign w_full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        o_p <= w_full;
    end

endmodule

// ===== test/mt19937_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt19937_checker: draw predictor and result checker
// Watches accepted transactions and result strobes and keeps its own MT19937
// state so that each draw can be compared with the expected tempered word.
// ----------------------------------------------------------------------------
module mt19937_checker #(
    parameter int KEY_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_seed_value,
    input  logic [31:0] i_key_word,
    input  logic        i_key_last,
    input  logic        i_valid,
    input  logic [31:0] i_rand_value,
    output int          o_pending,
    output int          o_errors
);

    localparam int N = 624;
    localparam int M = 397;

    bit [31:0] mix_words[N];
    int        next_pos;
    bit [31:0] pushed_keys[KEY_DEPTH];
    int        pushed_cnt;
    bit [31:0] draws_due[$];
    int        errors = 0;

    assign o_errors  = errors;

    function void fill_scalar(input bit [31:0] s);
        bit [31:0] p;
        mix_words[0] = s;
        for (int i = 1; i < N; i++) begin
            p = mix_words[i-1];
            mix_words[i] = 32'd1812433253 * (p ^ (p >> 30)) + i;
        end
        next_pos = N;
    endfunction

    function void fill_from_keys(input int len);
        int        i;
        int        j;
        bit [31:0] p;
        i = 1;
        j = 0;
        fill_scalar(32'd19650218);
        for (int k = (N > len) ? N : len; k > 0; k--) begin
            p = mix_words[i-1];
            mix_words[i] = (mix_words[i] ^ ((p ^ (p >> 30)) * 32'd1664525))
                           + pushed_keys[j] + j;
            i++;
            j++;
            if (i >= N) begin
                mix_words[0] = mix_words[N-1];
                i = 1;
            end
            if (j >= len) j = 0;
        end
        for (int k = N - 1; k > 0; k--) begin
            p = mix_words[i-1];
            mix_words[i] = (mix_words[i] ^ ((p ^ (p >> 30)) * 32'd1566083941)) - i;
            i++;
            if (i >= N) begin
                mix_words[0] = mix_words[N-1];
                i = 1;
            end
        end
        mix_words[0] = 32'h8000_0000;
        next_pos = N;
    endfunction

    function bit [31:0] next_tempered();
        bit [31:0] y;
        if (next_pos >= N) begin
            for (int i = 0; i < N; i++) begin
                y = (mix_words[i] & 32'h8000_0000) | (mix_words[(i+1)%N] & 32'h7fff_ffff);
                mix_words[i] = mix_words[(i+M)%N] ^ (y >> 1)
                               ^ (y[0] ? 32'h9908_b0df : 32'h0);
            end
            next_pos = 0;
        end
        y = mix_words[next_pos];
        next_pos++;
        y ^= y >> 11;
        y ^= (y << 7) & 32'h9d2c_5680;
        y ^= (y << 15) & 32'hefc6_0000;
        y ^= y >> 18;
        return y;
    endfunction

    task automatic report(input string what, input bit [31:0] got, input bit [31:0] want);
        $display("%0t ns: %s: got %08h, expected %08h", $time, what, got, want);
        errors++;
    endtask

    initial o_pending = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            // power-on key seeding
            pushed_keys[0] = 32'h123;
            pushed_keys[1] = 32'h234;
            pushed_keys[2] = 32'h345;
            pushed_keys[3] = 32'h456;
            fill_from_keys(4);
            pushed_cnt = 0;
            draws_due.delete();
        end else begin
            if (i_valid) begin
                if (draws_due.size() == 0)
                    report("unexpected draw result", i_rand_value, 32'h0);
                else if (i_rand_value !== draws_due[0])
                    report("rand_value mismatch", i_rand_value, draws_due.pop_front());
                else
                    void'(draws_due.pop_front());
            end
            if (i_start && !i_busy) begin
                case (mt_pkg::t_req'(i_req_type))
                    mt_pkg::REQ_SEED: begin
                        pushed_cnt = 0;
                        fill_scalar(i_seed_value);
                    end
                    mt_pkg::REQ_KEY: begin
                        if (pushed_cnt < KEY_DEPTH) begin
                            pushed_keys[pushed_cnt] = i_key_word;
                            pushed_cnt++;
                        end
                        if (i_key_last) begin
                            fill_from_keys(pushed_cnt);
                            pushed_cnt = 0;
                        end
                    end
                    mt_pkg::REQ_DRAW: draws_due.push_back(next_tempered());
                    default: ;
                endcase
            end
        end
        o_pending = draws_due.size();
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for mt19937_generator_top
// Directed seeding and draw cases, then random mixes of draw bursts, key
// sequences, scalar seeds and unused codes; a checker predicts every draw.
// ----------------------------------------------------------------------------
module testbench;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [1:0]  i_req_type = mt_pkg::REQ_NONE;
    logic [31:0] i_seed_value = '0;
    logic [31:0] i_key_word = '0;
    logic        i_key_last = 1'b0;
    logic        o_busy;
    logic        o_valid;
    logic [31:0] o_rand_value;
    int          pending;
    int          errors;
    int          sent = 0;      // counted transactions (unused code excluded)
    bit          steady = 1'b0; // no idle cycles while set

    always #10 i_clk = ~i_clk;

    mt19937_generator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req_type  (i_req_type),
        .i_seed_value(i_seed_value),
        .i_key_word  (i_key_word),
        .i_key_last  (i_key_last),
        .o_valid     (o_valid),
        .o_rand_value(o_rand_value)
    );

    mt19937_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_busy      (o_busy),
        .i_req_type  (i_req_type),
        .i_seed_value(i_seed_value),
        .i_key_word  (i_key_word),
        .i_key_last  (i_key_last),
        .i_valid     (o_valid),
        .i_rand_value(o_rand_value),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    // word with extra weight on the extremes
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // Random idle cycles in front of a transaction, about 28 in 100.
    // start is written here, in issue() and while draining, once per falling edge.
    task automatic maybe_idle();
        if (!steady && $urandom_range(0, 99) < 28) begin
            repeat ($urandom_range(1, 4)) begin
                @(negedge i_clk);
                i_start = 1'b0;
            end
        end
    endtask

    // One transaction: wait for a falling edge with busy low, drive, and let
    // the next rising edge take it. Unused fields carry the caller's values.
    task automatic issue(input mt_pkg::t_req req, input logic [31:0] seed,
                         input logic [31:0] key, input logic last);
        maybe_idle();
        @(negedge i_clk);
        while (o_busy) begin
            i_start = 1'b0;
            @(negedge i_clk);
        end
        i_start      = 1'b1;
        i_req_type   = req;
        i_seed_value = seed;
        i_key_word   = key;
        i_key_last   = last;
        @(posedge i_clk);
        if (req != mt_pkg::REQ_NONE) sent++;
    endtask

    task automatic draw_run(input int n);
        repeat (n) issue(mt_pkg::REQ_DRAW, pick_word(), pick_word(), $urandom_range(0, 1));
    endtask

    // Key sequence of len words, the last one flagged; an optional draw or an
    // unused code in the middle must leave the pending words alone.
    task automatic key_run(input int len, input bit interleave);
        for (int k = 0; k < len; k++) begin
            if (interleave && k == len / 2) begin
                if ($urandom_range(0, 1)) draw_run(1);
                else issue(mt_pkg::REQ_NONE, pick_word(), pick_word(), $urandom_range(0, 1));
            end
            issue(mt_pkg::REQ_KEY, pick_word(), pick_word(), k == len - 1);
        end
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        i_start = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // stop on a hang
    initial begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int pick;
        int next_drain;
        next_drain = 200;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: power-on key stream, unused code, seed extremes,
        // single-word key, draws while keys are pending, seed dropping keys.
        draw_run(3);
        issue(mt_pkg::REQ_NONE, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
        draw_run(1);
        issue(mt_pkg::REQ_SEED, 32'h0, 32'hffff_ffff, 1'b1);
        draw_run(2);
        issue(mt_pkg::REQ_SEED, 32'hffff_ffff, 32'h0, 1'b0);
        draw_run(2);
        issue(mt_pkg::REQ_SEED, 32'd5489, 32'h0, 1'b0);
        draw_run(1);
        issue(mt_pkg::REQ_KEY, 32'h0, 32'hffff_ffff, 1'b1);
        draw_run(1);
        issue(mt_pkg::REQ_KEY, 32'h0, 32'h0, 1'b0);
        draw_run(1);
        issue(mt_pkg::REQ_KEY, 32'hffff_ffff, 32'h8000_0001, 1'b1);
        draw_run(1);
        issue(mt_pkg::REQ_KEY, 32'h1, 32'h1234_5678, 1'b0);
        issue(mt_pkg::REQ_SEED, 32'h8000_0000, 32'h0, 1'b0);
        draw_run(1);
        hold_until_drained();

        // Random mix: mostly draws, with key sequences (sometimes past the
        // buffer depth), scalar seeds, broken sequences and unused codes.
        while (sent < 1750) begin
            steady = (sent >= 800 && sent < 1100);
            pick = $urandom_range(0, 99);
            if (pick < 58) begin
                // an occasional long run crosses the regeneration point
                draw_run(($urandom_range(0, 24) == 0 && sent < 1050)
                         ? 700 : $urandom_range(1, 20));
            end else if (pick < 74) begin
                key_run(($urandom_range(0, 7) == 0) ? $urandom_range(60, 70)
                                                    : $urandom_range(1, 8),
                        $urandom_range(0, 3) == 0);
            end else if (pick < 80) begin
                issue(mt_pkg::REQ_SEED, pick_word(), pick_word(), $urandom_range(0, 1));
            end else if (pick < 86) begin
                issue(mt_pkg::REQ_NONE, pick_word(), pick_word(), $urandom_range(0, 1));
            end else begin
                // broken key sequence, abandoned by a scalar seed
                repeat ($urandom_range(1, 5))
                    issue(mt_pkg::REQ_KEY, pick_word(), pick_word(), 1'b0);
                if ($urandom_range(0, 1)) draw_run(1);
                issue(mt_pkg::REQ_SEED, pick_word(), pick_word(), $urandom_range(0, 1));
            end
            if (sent >= next_drain) begin
                hold_until_drained();
                next_drain += 400;
            end
        end

        @(negedge i_clk);
        i_start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== mt19937_generator_top.f =====
src/mt_pkg.sv
src/mt_ram.sv
src/mt_mul.sv
src/mt19937_generator_top.sv
test/mt19937_checker.sv
test/testbench.sv
